// ===== sv/xed_pkg.sv =====
package xed_pkg;

  // longest entity is six bytes; an open match holds at most five of them
  localparam int HeldDepth = 5;
  localparam int PktBytes  = HeldDepth + 1;
  localparam int EntCount  = 6;
  localparam int EntWidth  = 6;

  localparam logic [7:0] CharAmp = 8'h26;

  // entity spellings, padded with zero past their length
  localparam logic [7:0] EntText [EntCount][EntWidth] = '{
    '{CharAmp, "a", "m", "p", ";", 8'h00},
    '{CharAmp, "l", "t", ";", 8'h00, 8'h00},
    '{CharAmp, "g", "t", ";", 8'h00, 8'h00},
    '{CharAmp, "q", "u", "o", "t", ";"},
    '{CharAmp, "a", "p", "o", "s", ";"},
    '{CharAmp, "#", "3", "9", ";", 8'h00}
  };

  localparam logic [2:0] EntLen [EntCount] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd5};

  localparam logic [7:0] EntChar [EntCount] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27};

  // one request's worth of output: cnt literal bytes, then a terminator if term
  typedef struct packed {
    logic [PktBytes-1:0][7:0] data;
    logic [2:0]               cnt;
    logic                     term;
  } xed_pkt_t;

endpackage

// ===== sv/xed_front.sv =====
module xed_front
  import xed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic [15:0] max_out_chars_i,
  output xed_pkt_t    pkt_o,
  output logic        pkt_valid_o
);

  logic [7:0]  held_q [HeldDepth];
  logic [7:0]  held_d [HeldDepth];
  logic [2:0]  hc_q, hc_d;
  logic [15:0] emitted_q, emitted_d;

  logic [15:0] rem;
  logic [2:0]  n;
  logic        full_hit, part_hit, pm;
  logic [7:0]  full_char;
  logic [2:0]  flush_n;
  logic        x_v;
  logic [7:0]  x;
  logic [2:0]  len, cnt;

  always_comb begin
    rem = (max_out_chars_i > emitted_q) ? (max_out_chars_i - emitted_q) : 16'd0;
    n   = hc_q + 3'd1;

    // compare the open candidate plus the new byte against every entity
    full_hit  = 1'b0;
    part_hit  = 1'b0;
    full_char = 8'h00;
    for (int e = 0; e < EntCount; e++) begin
      pm = (in_byte_i == EntText[e][hc_q]);
      for (int i = 0; i < HeldDepth; i++) begin
        if ((3'(i) < hc_q) && (held_q[i] != EntText[e][i])) pm = 1'b0;
      end
      if (pm && (EntLen[e] == n) && !full_hit) begin
        full_hit  = 1'b1;
        full_char = EntChar[e];
      end
      if (pm && (EntLen[e] > n)) part_hit = 1'b1;
    end

    held_d  = held_q;
    hc_d    = 3'd0;
    flush_n = 3'd0;
    x_v     = 1'b0;
    x       = in_byte_i;

    if (rem == 16'd0) begin
      hc_d = 3'd0;
    end else if (hc_q != 3'd0 && full_hit) begin
      x   = full_char;
      x_v = 1'b1;
    end else if (hc_q != 3'd0 && part_hit && n <= 3'(HeldDepth)) begin
      held_d[hc_q] = in_byte_i;
      hc_d         = n;
      if (in_last_i) begin
        flush_n = hc_q;
        x_v     = 1'b1;
      end
    end else begin
      // mismatch or nothing open: release held bytes, then treat the byte afresh
      flush_n = hc_q;
      if (in_byte_i == CharAmp) begin
        if (16'(hc_q) < rem) begin
          held_d[0] = in_byte_i;
          hc_d      = 3'd1;
          x_v       = in_last_i;
        end
      end else begin
        x_v = 1'b1;
      end
    end

    if (in_last_i) hc_d = 3'd0;

    len = flush_n + 3'(x_v);
    cnt = (rem < 16'(len)) ? rem[2:0] : len;

    for (int i = 0; i < HeldDepth; i++) begin
      pkt_o.data[i] = (3'(i) < flush_n) ? held_q[i] : x;
    end
    pkt_o.data[HeldDepth] = x;
    pkt_o.cnt  = cnt;
    pkt_o.term = in_last_i;

    emitted_d   = in_last_i ? 16'd0 : (emitted_q + 16'(cnt));
    pkt_valid_o = acc_i && ((cnt != 3'd0) || in_last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q      <= 3'd0;
      emitted_q <= 16'd0;
    end else if (acc_i) begin
      hc_q      <= hc_d;
      emitted_q <= emitted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) held_q <= held_d;
  end

`ifndef NO_ASSERTIONS
  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= 3'(HeldDepth))
    else $error("held count past holding depth");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && in_last_i |=> hc_q == 3'd0 && emitted_q == 16'd0)
    else $error("string end did not clear match state");

  a_last_pushes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && in_last_i |-> pkt_valid_o && pkt_o.term)
    else $error("string end produced no terminator request");
`endif

endmodule

// ===== sv/xed_queue.sv =====
module xed_queue
  import xed_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  xed_pkt_t pkt_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output xed_pkt_t head_o
);

  xed_pkt_t   slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= pkt_i;
  end

endmodule

// ===== sv/xed_back.sv =====
module xed_back
  import xed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  xed_pkt_t   head_i,
  input  logic       head_valid_i,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       deq_o
);

  logic [2:0] idx_q, idx_d;
  logic       on_term, take, done;

  always_comb begin
    on_term    = (idx_q == head_i.cnt);
    out_byte_o = on_term ? 8'h00 : head_i.data[idx_q];
    out_last_o = on_term;
    take       = pop_i && head_valid_i;
    done       = on_term || ((idx_q + 3'd1 == head_i.cnt) && !head_i.term);
    deq_o      = take && done;
    idx_d      = idx_q;
    if (take) idx_d = done ? 3'd0 : (idx_q + 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 3'd0;
    else         idx_q <= idx_d;
  end

`ifndef NO_ASSERTIONS
  a_idx_in_packet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.cnt)
    else $error("result index ran past its request");
`endif

endmodule

// ===== sv/xml_entity_decoder.sv =====
// channel   | direction | handshake            | payload
// input     | in        | push / full          | in_byte_i, in_last_i
// result    | out       | pop / empty          | out_byte_o, out_last_o
// config    | in        | apb psel/penable     | max_out_chars at byte address 0
//
// the front decodes one byte per cycle while the queue is not full and files
// one request per byte that yields output into a two-entry queue
// the back drains one result per cycle while pop is high and the queue is
// not empty; a byte yields zero to seven results
// full rises when both queue entries are taken; the front stalls only then
// reset clears match state, counters and queue, and sets the limit to 255
module xml_entity_decoder
  import xed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_q;
  logic        cfg_wr, sel_max;
  logic        in_acc;
  xed_pkt_t    pkt, head;
  logic        pkt_valid, deq;

  // register file: a single limit register at word 0
  assign pready  = 1'b1;
  assign sel_max = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && sel_max;
  assign prdata  = sel_max ? {16'h0000, max_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     max_q <= 16'd255;
    else if (cfg_wr) max_q <= pwdata[15:0];
  end

  // input accepted whenever the queue can take another request
  assign in_acc = push && !full;

  xed_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (in_acc),
    .in_byte_i       (in_byte_i),
    .in_last_i       (in_last_i),
    .max_out_chars_i (max_q),
    .pkt_o           (pkt),
    .pkt_valid_o     (pkt_valid)
  );

  // decouples classification from result delivery
  xed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_valid),
    .pkt_i   (pkt),
    .pop_i   (deq),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // serializes the head request into single results
  xed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .deq_o        (deq)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // register map, byte addresses
  localparam logic [2:0] AddrMaxOut = 3'd0;

  localparam logic [7:0] Amp = 8'h26;
  localparam int EntCount = 6;
  // longest open match the decoder keeps before giving up
  localparam int HeldMax = 5;

  // entity spellings, right-justified: byte i of entity e is read by entity_byte
  localparam logic [47:0] SpellBits [EntCount] = '{
    "&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&#39;"
  };
  localparam int SpellLen [EntCount] = '{5, 4, 4, 6, 6, 5};
  localparam logic [7:0] SpellChar [EntCount] = '{"&", "<", ">", "\"", "'", "'"};

  // one decoded character on its way out
  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } dec_t;

  // directed string: bytes right-justified, last byte carries in_last
  // where typed is set, want holds the characters before the terminator
  typedef struct packed {
    logic [95:0] text;
    logic [3:0]  text_len;
    logic [15:0] limit;
    logic        typed;
    logic [95:0] want;
    logic [3:0]  want_len;
  } row_t;

  localparam int RowCount = 10;
  localparam row_t DirectedRows [RowCount] = '{
    // every entity, decoded back to back
    '{"&amp;",        4'd5,  16'd255,   1'b1, "&",       4'd1},
    '{"&lt;&gt;",     4'd8,  16'd255,   1'b1, "<>",      4'd2},
    '{"&quot;",       4'd6,  16'd255,   1'b1, "\"",      4'd1},
    '{"&apos;&#39;",  4'd11, 16'd255,   1'b1, "''",      4'd2},
    // zero byte and byte extremes pass straight through
    '{{8'h00, 8'h01, 8'hff}, 4'd3, 16'd255, 1'b1, {8'h00, 8'h01, 8'hff}, 4'd3},
    // upper case never matches, the held bytes come out literally
    '{"&LT;",         4'd4,  16'd255,   1'b1, "&LT;",    4'd4},
    // second ampersand restarts the match, last flushes the open one
    '{"&&lt",         4'd4,  16'd255,   1'b0, 96'h0,     4'd0},
    // truncation after one character
    '{"ab",           4'd2,  16'd1,     1'b1, "a",       4'd1},
    // zero limit: only the terminator
    '{"&",            4'd1,  16'd0,     1'b1, 96'h0,     4'd0},
    // top limit, open match flushed by the last byte
    '{"&q",           4'd2,  16'd65535, 1'b1, "&q",      4'd2}
  };

  // random phases: limit per phase, lowered mid-string after the cut phases
  localparam int PhaseCount = 9;
  localparam int PhaseItems = 36;
  localparam logic [15:0] PhaseLimit [PhaseCount] = '{
    16'd255, 16'd7, 16'd65535, 16'd1, 16'd3, 16'd0, 16'd40, 16'd12, 16'd2
  };

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte_i;
  logic        in_last_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // decoder mirror: limit register, open match and per-string count
  logic [15:0] out_limit;
  logic [7:0]  held [HeldMax];
  int          held_n;
  logic [15:0] emitted;

  dec_t        decoded_q [$];
  dec_t        oldest;
  logic [7:0]  text_q [$];
  int          mismatches;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          predict_on;

  xml_entity_decoder u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [7:0] entity_byte(int e, int i);
    return SpellBits[e][(SpellLen[e] - 1 - i) * 8 +: 8];
  endfunction

  // emit one character unless the string is already at its limit
  function automatic void put_char(logic [7:0] c);
    if (emitted >= out_limit) return;
    decoded_q.push_back('{c, 1'b0});
    emitted++;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) put_char(held[i]);
    held_n = 0;
  endfunction

  // byte seen with no open match: an ampersand opens one, anything else passes
  function automatic void open_or_pass(logic [7:0] c);
    if (c == Amp) begin
      if (emitted < out_limit) begin
        held[0] = c;
        held_n = 1;
      end
    end else begin
      put_char(c);
    end
  endfunction

  // expected results of one accepted request
  function automatic void decode_char(logic [7:0] c, logic l);
    logic [7:0] cand [HeldMax + 1];
    int  n;
    int  hit_e;
    bit  partial;
    bit  same;
    hit_e = -1;
    partial = 1'b0;
    if (emitted >= out_limit) begin
      // truncated: everything is dropped until the last byte
      held_n = 0;
    end else if (held_n == 0) begin
      open_or_pass(c);
    end else begin
      n = held_n + 1;
      for (int i = 0; i < held_n; i++) cand[i] = held[i];
      cand[held_n] = c;
      for (int e = 0; e < EntCount; e++) begin
        if (SpellLen[e] >= n) begin
          same = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (entity_byte(e, i) != cand[i]) same = 1'b0;
          end
          if (same && SpellLen[e] == n) hit_e = e;
          else if (same) partial = 1'b1;
        end
      end
      if (hit_e >= 0) begin
        held_n = 0;
        put_char(SpellChar[hit_e]);
      end else if (partial && n <= HeldMax) begin
        held[held_n] = c;
        held_n = n;
      end else begin
        // match broken: held bytes go out literally, new byte handled afresh
        flush_held();
        open_or_pass(c);
      end
    end
    if (l) begin
      flush_held();
      decoded_q.push_back('{8'h00, 1'b1});
      held_n = 0;
      emitted = 0;
    end
  endfunction

  // random string built from entities, broken prefixes, case flips and noise
  function automatic void build_text();
    int e;
    int cut_at;
    int pieces;
    text_q.delete();
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      e = $urandom_range(0, EntCount - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int i = 0; i < SpellLen[e]; i++) text_q.push_back(entity_byte(e, i));
        end
        4, 5: begin
          cut_at = $urandom_range(1, SpellLen[e] - 1);
          for (int i = 0; i < cut_at; i++) text_q.push_back(entity_byte(e, i));
          text_q.push_back(8'($urandom_range(1, 255)));
        end
        6: begin
          // flip the case of the byte after the ampersand
          for (int i = 0; i < SpellLen[e]; i++) begin
            text_q.push_back(i == 1 ? entity_byte(e, i) ^ 8'h20 : entity_byte(e, i));
          end
        end
        7: text_q.push_back(Amp);
        default: text_q.push_back(8'($urandom_range(1, 255)));
      endcase
    end
  endfunction

  // one request on the input side, with random gaps before it
  task automatic send_char(input logic [7:0] c, input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= c;
    in_last_i <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_on) decode_char(c, l);
  endtask

  // stop sending and wait for every expected result
  task automatic hold_until_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // setup then access phase; psel is left high for the caller to drop or reuse
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= AddrMaxOut;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    penable <= 1'b0;
  endtask

  task automatic check_limit_reg(input logic [15:0] want);
    logic [31:0] got;
    apb_access(1'b0, 32'h0, got);
    psel <= 1'b0;
    if (got !== {16'h0, want}) begin
      $display("%0t: max_out_chars readback expected %08h actual %08h",
               $time, {16'h0, want}, got);
      mismatches++;
    end
  endtask

  // limit change only with the decoder idle, then read it back
  task automatic write_limit(input logic [15:0] v);
    logic [31:0] unused;
    hold_until_drained();
    // a held match yields no result, so give the pipeline time to settle
    repeat (10) @(posedge clk_i);
    apb_access(1'b1, {16'h0, v}, unused);
    out_limit = v;
    check_limit_reg(v);
  endtask

  // receiver: pop drops at random per the current idle rate
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // every popped result against the oldest expectation, field by field
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, actual byte %02h last %0b",
                 $time, out_byte_o, out_last_o);
        mismatches++;
      end else begin
        oldest = decoded_q.pop_front();
        if (out_byte_o !== oldest.ch) begin
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, oldest.ch, out_byte_o);
          mismatches++;
        end
        if (out_last_o !== oldest.term) begin
          $display("%0t: out_last expected %0b actual %0b",
                   $time, oldest.term, out_last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    row_t row;
    int   sent;
    bit   paused;
    bit   cut;
    rst_ni <= 1'b0;
    push <= 1'b0;
    in_byte_i <= 8'h00;
    in_last_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AddrMaxOut;
    pwdata <= 32'h0;
    mismatches = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    predict_on = 1'b1;
    out_limit = 16'd255;
    held_n = 0;
    emitted = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limit comes out of reset at 255
    check_limit_reg(16'd255);

    // directed strings, no idling; typed rows bypass the mirror, each row
    // ends on its last byte so the mirror is back at a fresh string anyway
    for (int r = 0; r < RowCount; r++) begin
      row = DirectedRows[r];
      if (row.limit != out_limit) write_limit(row.limit);
      predict_on = !row.typed;
      if (row.typed) begin
        for (int i = 0; i < row.want_len; i++) begin
          decoded_q.push_back('{row.want[(row.want_len - 1 - i) * 8 +: 8], 1'b0});
        end
        decoded_q.push_back('{8'h00, 1'b1});
      end
      for (int i = 0; i < row.text_len; i++) begin
        send_char(row.text[(row.text_len - 1 - i) * 8 +: 8], i == row.text_len - 1);
      end
    end
    predict_on = 1'b1;

    // random strings: sender-light/receiver-heavy idling, then swapped, then none
    for (int p = 0; p < PhaseCount; p++) begin
      case (p / 3)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_limit(PhaseLimit[p]);
      sent = 0;
      paused = 1'b0;
      while (sent < PhaseItems) begin
        build_text();
        // even phases but the last end mid-string so the next limit lands inside it
        cut = (p % 2 == 0) && (p < PhaseCount - 1) && (sent + text_q.size() >= PhaseItems);
        for (int i = 0; i < text_q.size(); i++) begin
          send_char(text_q[i], (i == text_q.size() - 1) && !cut);
        end
        sent += text_q.size();
        // mid-phase hold-off until the output side has caught up
        if (!paused && sent >= PhaseItems / 2) begin
          paused = 1'b1;
          hold_until_drained();
        end
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
